@@ src/swmm_pkg.sv @@
// Shared types, sizes and helpers for the sliding-window max/min filter.
// Used by every module of the block; depends on nothing else.
package swmm_pkg;

  // Window and storage sizes
  localparam int MAX_RADIUS   = 31;
  localparam int WIN_DEPTH    = 2 * MAX_RADIUS + 1;
  // Command queue depth; keep it a power of two (pointers wrap naturally)
  localparam int QUEUE_DEPTH  = 4;
  // Sample store spans the window plus every sample the front end may write
  // ahead of the scan: the opening samples of a line that release no result
  // and one sample per queued command
  localparam int MEM_AW       = $clog2(WIN_DEPTH + MAX_RADIUS + QUEUE_DEPTH + 2);
  localparam int RAD_W        = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W        = $clog2(WIN_DEPTH + 1);
  localparam int Q_AW         = $clog2(QUEUE_DEPTH);
  localparam int Q_CW         = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W        = 5;
  localparam int RADIUS_RESET = 2;

  typedef logic [7:0] sample_t;

  // Input item
  typedef struct packed {
    sample_t sample;
    logic    last;
  } swmm_in_t;

  // Result item
  typedef struct packed {
    sample_t max_value;
    sample_t min_value;
    logic    line_end;
  } swmm_out_t;

  // Work for the back end: scan slots ptr, ptr-1 .. ptr-hi
  typedef struct packed {
    logic [MEM_AW-1:0] ptr;
    logic [WIN_W-1:0]  hi;
    logic              line_end;
  } swmm_cmd_t;

  // Sample store write request from the front end
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    sample_t           data;
  } swmm_wr_t;

  // Limit a configured radius to what the store can cover
  function automatic logic [RAD_W-1:0] clamp_radius(input logic [CFG_W-1:0] r);
    if (int'(r) > MAX_RADIUS) begin
      return RAD_W'(MAX_RADIUS);
    end
    return RAD_W'(r);
  endfunction

endpackage

@@ src/swmm_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on swmm_pkg for the command type and queue depth.
module swmm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  swmm_pkg::swmm_cmd_t push_cmd,
  input  logic                pop,
  output swmm_pkg::swmm_cmd_t pop_cmd,
  output logic                full,
  output logic                empty
);
  import swmm_pkg::*;

  swmm_cmd_t       slots [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full    = (count == Q_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Store a pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

@@ src/swmm_front.sv @@
// Front end: accepts samples, writes the sample store, tracks the line and
// issues one scan command per result. Depends on swmm_pkg.
module swmm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [swmm_pkg::CFG_W-1:0] radius,
  input  swmm_pkg::swmm_in_t        item,
  input  logic                      item_valid,
  output logic                      item_stall,
  output swmm_pkg::swmm_wr_t        wr,
  output logic                      push,
  output swmm_pkg::swmm_cmd_t       push_cmd,
  input  logic                      q_full
);
  import swmm_pkg::*;

  logic [MEM_AW-1:0] wp;
  logic [WIN_W-1:0]  cnt;
  logic [RAD_W-1:0]  lr;
  logic              flushing;
  logic [RAD_W-1:0]  fl_back;
  logic [WIN_W-1:0]  fl_avail;

  logic              accept;
  logic [RAD_W-1:0]  r_cur;
  logic [WIN_W-1:0]  new_cnt;
  logic [WIN_W-1:0]  r_wide;
  logic [WIN_W-1:0]  two_r;
  logic [WIN_W-1:0]  last_idx;
  logic [WIN_W-1:0]  fl_reach;
  logic [WIN_W-1:0]  fl_top;
  logic [MEM_AW-1:0] wp_next;

  assign item_stall = flushing || q_full;
  assign accept     = item_valid && !item_stall;

  // Radius in force: latch a fresh one at the first sample of a line
  assign r_cur    = (cnt == '0) ? clamp_radius(radius) : lr;
  assign new_cnt  = (cnt == WIN_W'(WIN_DEPTH)) ? cnt : cnt + 1'b1;
  assign r_wide   = WIN_W'(r_cur);
  assign two_r    = r_wide << 1;
  assign last_idx = new_cnt - 1'b1;
  assign wp_next  = wp + 1'b1;

  // Flush reach for the position fl_back samples behind the newest
  assign fl_reach = WIN_W'(fl_back) + WIN_W'(lr);
  assign fl_top   = fl_avail - 1'b1;

  // Sample store write
  always_comb begin
    wr.en   = accept;
    wr.addr = wp_next;
    wr.data = item.sample;
  end

  // Build the scan command for a steady result or a flush result
  always_comb begin
    push_cmd = '0;
    push     = 1'b0;
    if (flushing) begin
      push              = !q_full;
      push_cmd.ptr      = wp;
      push_cmd.hi       = (fl_reach < fl_top) ? fl_reach : fl_top;
      push_cmd.line_end = (fl_back == '0);
    end else begin
      push              = accept && !item.last && (new_cnt > r_wide);
      push_cmd.ptr      = wp_next;
      push_cmd.hi       = (two_r < last_idx) ? two_r : last_idx;
      push_cmd.line_end = 1'b0;
    end
  end

  // Track line position and run the end-of-line flush
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      cnt      <= '0;
      lr       <= clamp_radius(CFG_W'(RADIUS_RESET));
      flushing <= 1'b0;
      fl_back  <= '0;
      fl_avail <= '0;
    end else if (flushing) begin
      if (!q_full) begin
        if (fl_back == '0) begin
          flushing <= 1'b0;
        end else begin
          fl_back <= fl_back - 1'b1;
        end
      end
    end else if (accept) begin
      wp <= wp_next;
      lr <= r_cur;
      if (item.last) begin
        cnt      <= '0;
        flushing <= 1'b1;
        fl_avail <= new_cnt;
        fl_back  <= (last_idx < r_wide) ? RAD_W'(last_idx) : r_cur;
      end else begin
        cnt <= new_cnt;
      end
    end
  end

endmodule

@@ src/swmm_back.sv @@
// Back end: holds the sample store, scans one window per command through a
// single read port and keeps the result in an output register. Depends on swmm_pkg.
module swmm_back (
  input  logic                clk,
  input  logic                rst,
  input  swmm_pkg::swmm_wr_t  wr,
  input  swmm_pkg::swmm_cmd_t cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output swmm_pkg::swmm_out_t result,
  output logic                result_valid,
  input  logic                result_stall
);
  import swmm_pkg::*;

  sample_t           mem [2**MEM_AW];
  sample_t           rd_data;

  logic              busy;
  logic              first;
  logic [WIN_W-1:0]  issue_cnt;
  logic [MEM_AW-1:0] rd_addr;
  logic              end_flag;
  logic              rd_pend;
  logic              rd_first;
  logic              rd_last;
  sample_t           acc_max;
  sample_t           acc_min;
  sample_t           cur_max;
  sample_t           cur_min;

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (busy) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Take a new command only when the previous result has left the scan
  assign cmd_pop = !busy && !rd_pend && !cmd_empty && (!result_valid || !result_stall);

  // Fold the returning sample into the running max and min
  always_comb begin
    if (rd_first) begin
      cur_max = rd_data;
      cur_min = rd_data;
    end else begin
      cur_max = (rd_data > acc_max) ? rd_data : acc_max;
      cur_min = (rd_data < acc_min) ? rd_data : acc_min;
    end
  end

  // Hold running values and the result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rd_addr  <= cmd.ptr;
      end_flag <= cmd.line_end;
    end else if (busy) begin
      rd_addr <= rd_addr - 1'b1;
    end
    if (rd_pend) begin
      acc_max <= cur_max;
      acc_min <= cur_min;
      if (rd_last) begin
        result.max_value <= cur_max;
        result.min_value <= cur_min;
        result.line_end  <= end_flag;
      end
    end
  end

  // Sequence the scan and the output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      first        <= 1'b0;
      issue_cnt    <= '0;
      rd_pend      <= 1'b0;
      rd_first     <= 1'b0;
      rd_last      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_pend <= busy;
      if (cmd_pop) begin
        busy      <= 1'b1;
        first     <= 1'b1;
        issue_cnt <= cmd.hi;
      end else if (busy) begin
        first     <= 1'b0;
        rd_first  <= first;
        rd_last   <= (issue_cnt == '0);
        issue_cnt <= issue_cnt - 1'b1;
        if (issue_cnt == '0) begin
          busy <= 1'b0;
        end
      end
      if (rd_pend && rd_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && rd_last) |-> (!result_valid || !result_stall))
    else $error("result finished while output register is still held");
  a_one_scan: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (!busy && !rd_pend))
    else $error("new scan started over a running one");
  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(busy))
    else $error("read data taken without an issued read");
`endif

endmodule

@@ src/sliding_window_max_min_filter.sv @@
// Sliding-window max/min filter top level: config register, front end,
// command queue and back end. Depends on swmm_pkg and the swmm_* modules.
//
// Samples of one line enter on the item channel, the final one flagged by
// last. For each position the block returns the maximum and minimum over the
// centred window of 2*radius+1 samples, clipped to the line; results lag the
// input by radius samples and the tail of the line is flushed after the last
// sample. The radius register (reset 2, capped at 31) is sampled at the first
// sample of each line. The front end takes one sample per cycle while its
// four-entry command queue has room; after a last sample it stalls the input
// while it queues the flush. The back end scans the clipped window of each
// result, w samples wide (at most 63), one sample a cycle through the single
// read port of the sample store; that scan sets the sustained rate.
// No clearing pass is needed after reset.
module sliding_window_max_min_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       radius_valid,
  output logic                       radius_ready,
  input  logic [swmm_pkg::CFG_W-1:0] radius_data,
  input  swmm_pkg::swmm_in_t         item,
  input  logic                       item_valid,
  output logic                       item_stall,
  output swmm_pkg::swmm_out_t        result,
  output logic                       result_valid,
  input  logic                       result_stall
);
  import swmm_pkg::*;

  logic [CFG_W-1:0] radius;
  swmm_wr_t         wr;
  logic             push;
  swmm_cmd_t        push_cmd;
  logic             pop;
  swmm_cmd_t        pop_cmd;
  logic             q_full;
  logic             q_empty;

  // Radius register, always writable
  assign radius_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= CFG_W'(RADIUS_RESET);
    end else if (radius_valid && radius_ready) begin
      radius <= radius_data;
    end
  end

  swmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .radius     (radius),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .wr         (wr),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  swmm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  swmm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .cmd          (pop_cmd),
    .cmd_empty    (q_empty),
    .cmd_pop      (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
